// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the receiver RTL.
// Each macro takes a label, the clock, the active-low reset and two expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/ps2kr_pkg.sv =====
package ps2kr_pkg;

  localparam int BUFFER_DEPTH_DEF = 64;

  // Character maps: one memory, the map select is the top address bit.
  localparam int CODE_W    = 8;
  localparam int CHAR_W    = 8;
  localparam int MAP_AW    = CODE_W + 1;
  localparam int MAP_DEPTH = 1 << MAP_AW;

  localparam logic [3:0] PHASE_IDLE   = 4'd11;
  localparam logic [3:0] PHASE_FIRST  = 4'd10;
  localparam logic [3:0] PHASE_LAST   = 4'd3;
  localparam logic [3:0] PHASE_PARITY = 4'd2;
  localparam logic [3:0] PHASE_STOP   = 4'd1;

  localparam logic [CODE_W-1:0] CODE_RELEASE = 8'hF0;
  localparam logic [CODE_W-1:0] CODE_LSHIFT  = 8'h12;
  localparam logic [CODE_W-1:0] CODE_RSHIFT  = 8'h59;

  typedef enum logic [1:0] {
    KIND_EDGE   = 2'd0,
    KIND_MAP_WR = 2'd1,
    KIND_READ   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  // Lookup request from the frame decoder to the character maps.
  typedef struct packed {
    logic              lookup;
    logic [MAP_AW-1:0] addr;
  } map_req_t;

  // Operation carried by a request into the ring buffer stage.
  typedef struct packed {
    logic push;
    logic pop;
  } buf_op_t;

endpackage

// ===== rtl/ps2kr_if.sv =====
interface ps2kr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic       data_bit;
  logic       map_select;
  logic [7:0] map_code;
  logic [7:0] map_char;

  modport source(output valid, kind, data_bit, map_select, map_code, map_char, input ready);
  modport sink(input valid, kind, data_bit, map_select, map_code, map_char, output ready);
endinterface

interface ps2kr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       char_valid;

  modport source(output valid, char_out, char_valid, input ready);
  modport sink(input valid, char_out, char_valid, output ready);
endinterface

// ===== rtl/ps2kr_frame.sv =====
module ps2kr_frame
  import ps2kr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     edge_en,
  input  logic     data_bit,
  output map_req_t req
);

  logic [3:0]        phase_r, phase_nxt;
  logic [CODE_W-1:0] sreg_r, sreg_nxt;
  logic              rel_r, rel_nxt;
  logic              shift_r, shift_nxt;
  logic              is_shift;

  assign is_shift = (sreg_r == CODE_LSHIFT) || (sreg_r == CODE_RSHIFT);

  always_comb begin
    phase_nxt  = phase_r;
    sreg_nxt   = sreg_r;
    rel_nxt    = rel_r;
    shift_nxt  = shift_r;
    req.lookup = 1'b0;
    if (edge_en) begin
      case (phase_r) inside
        PHASE_IDLE: begin
          if (!data_bit) phase_nxt = PHASE_FIRST;
        end
        PHASE_PARITY: phase_nxt = PHASE_STOP;
        PHASE_STOP: begin
          phase_nxt = PHASE_IDLE;
          // A good stop bit hands the byte to the scancode decoder.
          if (data_bit) begin
            if (sreg_r == CODE_RELEASE) begin
              rel_nxt = 1'b1;
            end else if (rel_r) begin
              rel_nxt = 1'b0;
              if (is_shift) shift_nxt = 1'b0;
            end else begin
              if (is_shift) shift_nxt = 1'b1;
              req.lookup = (sreg_r != '0);
            end
          end
        end
        [PHASE_LAST:PHASE_FIRST]: begin
          sreg_nxt  = {data_bit, sreg_r[CODE_W-1:1]};
          phase_nxt = phase_r - 4'd1;
        end
        default: phase_nxt = PHASE_IDLE;
      endcase
    end
    req.addr = {shift_nxt, sreg_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PHASE_IDLE;
      sreg_r  <= '0;
      rel_r   <= 1'b0;
      shift_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      sreg_r  <= sreg_nxt;
      rel_r   <= rel_nxt;
      shift_r <= shift_nxt;
    end
  end

endmodule

// ===== rtl/ps2kr_map.sv =====
module ps2kr_map
  import ps2kr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [MAP_AW-1:0] wr_addr,
  input  logic [CHAR_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [MAP_AW-1:0] rd_addr,
  output logic [CHAR_W-1:0] rd_data,
  output logic              busy
);

  logic [CHAR_W-1:0] map_mem [MAP_DEPTH];
  logic [MAP_AW-1:0] clr_addr_r, clr_addr_nxt;
  logic              busy_r, busy_nxt;

  // After reset both maps are swept to zero, one entry per cycle.
  always_comb begin
    clr_addr_nxt = clr_addr_r;
    busy_nxt     = busy_r;
    if (busy_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == '1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      busy_r     <= 1'b1;
    end else begin
      clr_addr_r <= clr_addr_nxt;
      busy_r     <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      map_mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    if (rd_en) rd_data <= map_mem[rd_addr];
  end

  assign busy = busy_r;

endmodule

// ===== rtl/ps2kr_cbuf.sv =====
module ps2kr_cbuf
  import ps2kr_pkg::*;
#(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  buf_op_t           op,
  input  logic [CHAR_W-1:0] push_char,
  input  logic              rd_en,
  output logic              hit,
  output logic [CHAR_W-1:0] rd_data
);

  localparam int PTR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUFFER_DEPTH - 1);

  logic [CHAR_W-1:0] buf_mem [BUFFER_DEPTH];
  logic [PTR_W-1:0]  wp_r, wp_nxt;
  logic [PTR_W-1:0]  rp_r, rp_nxt;
  logic              push;

  // Pushes and pops run in request order through this one stage, so the
  // pointers are always current here.
  assign push = en && op.push && (push_char != '0);
  assign hit  = en && op.pop && (rp_r != wp_r);

  always_comb begin
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    if (push) wp_nxt = (wp_r == PTR_LAST) ? '0 : wp_r + 1'b1;
    if (hit)  rp_nxt = (rp_r == PTR_LAST) ? '0 : rp_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) buf_mem[wp_r] <= push_char;
    if (rd_en) rd_data <= buf_mem[rp_r];
  end

endmodule

// ===== rtl/ps2kr_top.sv =====
// PS/2 keyboard receiver. Every request gets exactly one response, in order.
// A keyboard clock edge request shifts one frame bit; a complete scancode is
// decoded (release prefix, shift keys) and looked up in the plain or shifted
// character map, and a nonzero character is pushed into a ring buffer of
// BUFFER_DEPTH entries that overwrites when it wraps. A map write request
// loads one map entry. A read request pops one character and returns it with
// char_valid high, or zero when the buffer is empty; all other requests
// return zero. The block takes one request per clock cycle while in_chan.ready
// is high; each response is held in an output register, so a waiting response
// does not stop new requests until the three internal stages are full. The
// pipeline is: request and frame decode with the map read, then ring buffer
// push or pop with the buffer read, then the output register. After reset the
// block clears both character maps (512 entries) one per cycle and holds
// in_chan.ready low while it does so.
`include "assert_macros.svh"
module ps2_keyboard_receiver_top
  import ps2kr_pkg::*;
#(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input logic         clk,
  input logic         rst_n,
  ps2kr_in_if.sink    in_chan,
  ps2kr_out_if.source out_chan
);

  logic              load_1, load_2, load_o;
  logic              accept;
  kind_t             kind;
  logic              clr_busy;
  map_req_t          map_req;
  logic [CHAR_W-1:0] map_rd;
  logic [CHAR_W-1:0] buf_rd;
  logic              pop_hit;

  logic              s1_valid_r, s1_valid_nxt;
  buf_op_t           s1_op_r, s1_op_nxt;
  logic              s2_valid_r, s2_valid_nxt;
  logic              s2_hit_r, s2_hit_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic              out_cv_r, out_cv_nxt;

  // Elastic pipeline: each stage advances when the stage after it has room.
  assign load_o = !out_valid_r || out_chan.ready;
  assign load_2 = !s2_valid_r || load_o;
  assign load_1 = !s1_valid_r || load_2;

  assign in_chan.ready = load_1 && !clr_busy;
  assign accept        = in_chan.valid && in_chan.ready;
  assign kind          = kind_t'(in_chan.kind);

  ps2kr_frame u_frame (
    .clk      (clk),
    .rst_n    (rst_n),
    .edge_en  (accept && (kind == KIND_EDGE)),
    .data_bit (in_chan.data_bit),
    .req      (map_req)
  );

  ps2kr_map u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept && (kind == KIND_MAP_WR)),
    .wr_addr ({in_chan.map_select, in_chan.map_code}),
    .wr_data (in_chan.map_char),
    .rd_en   (load_1),
    .rd_addr (map_req.addr),
    .rd_data (map_rd),
    .busy    (clr_busy)
  );

  ps2kr_cbuf #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_cbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (s1_valid_r && load_2),
    .op        (s1_op_r),
    .push_char (map_rd),
    .rd_en     (load_2),
    .hit       (pop_hit),
    .rd_data   (buf_rd)
  );

  // The map read data lines up with the request held in stage one, and the
  // buffer read data with the request held in stage two.
  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    s1_op_nxt     = s1_op_r;
    s2_valid_nxt  = s2_valid_r;
    s2_hit_nxt    = s2_hit_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_cv_nxt    = out_cv_r;
    if (load_1) begin
      s1_valid_nxt  = accept;
      s1_op_nxt.push = accept && map_req.lookup;
      s1_op_nxt.pop  = accept && (kind == KIND_READ);
    end
    if (load_2) begin
      s2_valid_nxt = s1_valid_r;
      s2_hit_nxt   = pop_hit;
    end
    if (load_o) begin
      out_valid_nxt = s2_valid_r;
      out_char_nxt  = s2_hit_r ? buf_rd : '0;
      out_cv_nxt    = s2_hit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_op_r    <= s1_op_nxt;
    s2_hit_r   <= s2_hit_nxt;
    out_char_r <= out_char_nxt;
    out_cv_r   <= out_cv_nxt;
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.char_out   = out_char_r;
  assign out_chan.char_valid = out_cv_r;

  `ASSERT_IMP(a_no_req_while_clearing, clk, rst_n, accept, !clr_busy)
  `ASSERT_IMP(a_empty_resp_zero, clk, rst_n, out_valid_r && !out_cv_r, out_char_r == '0)
  `ASSERT_NXT(a_stage1_holds, clk, rst_n, s1_valid_r && !load_2, s1_valid_r)
  `ASSERT_NXT(a_hit_only_on_pop, clk, rst_n, load_2 && !(s1_valid_r && s1_op_r.pop), !s2_hit_r)

endmodule

// ===== dv/tb.sv =====
module tb;
  import ps2kr_pkg::*;

  // The ring buffer in the block uses the default depth from the package.
  localparam int RING_DEPTH = BUFFER_DEPTH_DEF;

  // One request as the sender presents it. The hold flag makes the driver wait
  // until every response that is still due has come back before it shows this one.
  typedef struct packed {
    kind_t      kind;
    logic       data_bit;
    logic       map_select;
    logic [7:0] map_code;
    logic [7:0] map_char;
    bit         hold;
  } kb_req_t;

  // One response: the popped character and the flag that says a pop happened.
  typedef struct packed {
    logic [7:0] ch;
    logic       vld;
  } kb_resp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ps2kr_in_if  req_bus ();
  ps2kr_out_if resp_bus ();

  ps2_keyboard_receiver_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_bus),
    .out_chan (resp_bus)
  );

  always #4 clk = ~clk;

  // Requests waiting to be shown, and responses the model says are still due.
  kb_req_t  kb_reqs [$];
  kb_resp_t due_resp [$];

  // The request currently held on the bus, used by the model when it is taken.
  kb_req_t shown;

  // Idle behavior of the current phase, in percent of cycles.
  int gap_pct = 0;
  int stall_pct = 0;

  int  mismatches = 0;
  int  n_added = 0;
  bit  hold_next = 1'b0;

  // Scancodes with entries in both maps, so that frames produce characters often.
  logic [7:0] code_pool [16];

  // Model state: frame assembly, scancode decode, ring buffer and both maps.
  logic [3:0] frame_phase;
  logic [7:0] frame_bits;
  logic       release_seen;
  logic       shift_held;
  int         wr_idx;
  int         rd_idx;
  logic [7:0] ring [RING_DEPTH];
  logic [7:0] plain_chars [256];
  logic [7:0] shifted_chars [256];

  // Applies one taken request to the model and returns the response it must cause.
  // Every request gets exactly one response; only a read of a nonempty buffer
  // returns a character.
  function automatic kb_resp_t decode_request(input kb_req_t r);
    kb_resp_t   resp;
    logic [7:0] sc;
    logic [7:0] ch;
    logic       is_shift;
    resp = '0;
    case (r.kind)
      KIND_EDGE: begin
        if (frame_phase == PHASE_IDLE) begin
          // A high level while idle is not a start bit, so keep waiting.
          if (!r.data_bit) frame_phase = PHASE_FIRST;
        end else if (frame_phase == PHASE_PARITY) begin
          frame_phase = PHASE_STOP;
        end else if (frame_phase == PHASE_STOP) begin
          frame_phase = PHASE_IDLE;
          // A low stop bit drops the whole frame.
          if (r.data_bit) begin
            sc = frame_bits;
            is_shift = (sc == CODE_LSHIFT) || (sc == CODE_RSHIFT);
            if (sc == CODE_RELEASE) begin
              release_seen = 1'b1;
            end else if (release_seen) begin
              // The released code is swallowed; only a shift release matters.
              release_seen = 1'b0;
              if (is_shift) shift_held = 1'b0;
            end else begin
              if (is_shift) shift_held = 1'b1;
              // Shift codes fall through to the lookup as well.
              ch = shift_held ? shifted_chars[sc] : plain_chars[sc];
              if (sc != 8'h00 && ch != 8'h00) begin
                ring[wr_idx] = ch;
                wr_idx = (wr_idx + 1) % RING_DEPTH;
              end
            end
          end
        end else if (frame_phase >= PHASE_LAST && frame_phase <= PHASE_FIRST) begin
          // Data bits arrive LSB first.
          frame_bits = {r.data_bit, frame_bits[7:1]};
          frame_phase = frame_phase - 4'd1;
        end else begin
          frame_phase = PHASE_IDLE;
        end
      end
      KIND_MAP_WR: begin
        if (r.map_select) shifted_chars[r.map_code] = r.map_char;
        else plain_chars[r.map_code] = r.map_char;
      end
      KIND_READ: begin
        // The buffer has no full flag: equal pointers always read as empty.
        if (rd_idx != wr_idx) begin
          resp.ch = ring[rd_idx];
          resp.vld = 1'b1;
          rd_idx = (rd_idx + 1) % RING_DEPTH;
        end
      end
      default: ;
    endcase
    return resp;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic add_req(input kind_t k, input logic b, input logic s,
                         input logic [7:0] code, input logic [7:0] ch);
    kb_req_t r;
    r.kind = k;
    r.data_bit = b;
    r.map_select = s;
    r.map_code = code;
    r.map_char = ch;
    r.hold = hold_next;
    hold_next = 1'b0;
    kb_reqs.push_back(r);
    n_added++;
  endtask

  // Queues the eleven keyboard clock edges of one frame. Fields that an edge
  // does not use are random, and so is the parity bit, which the block ignores.
  task automatic add_frame(input logic [7:0] sc, input logic stop_bit);
    add_req(KIND_EDGE, 1'b0, 1'($urandom), 8'($urandom), 8'($urandom));
    for (int i = 0; i < 8; i++)
      add_req(KIND_EDGE, sc[i], 1'($urandom), 8'($urandom), 8'($urandom));
    add_req(KIND_EDGE, 1'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
    add_req(KIND_EDGE, stop_bit, 1'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // A random mix that is mostly well-formed frames, with map writes and reads in
  // between, and some noise: stray high edges, truncated frames, unused kinds.
  task automatic add_random_mix(input int count);
    int         first;
    int         pick;
    int         p;
    logic [7:0] sc;
    first = n_added;
    while (n_added - first < count) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        p = $urandom_range(99);
        if (p < 10) sc = CODE_RELEASE;
        else if (p < 16) sc = CODE_LSHIFT;
        else if (p < 22) sc = CODE_RSHIFT;
        else if (p < 26) sc = 8'h00;
        else if (p < 75) sc = code_pool[$urandom_range(15)];
        else sc = 8'($urandom);
        if ($urandom_range(99) < 5)
          add_req(KIND_EDGE, 1'b1, 1'($urandom), 8'($urandom), 8'($urandom));
        add_frame(sc, $urandom_range(99) >= 8);
      end else if (pick < 67) begin
        add_req(KIND_MAP_WR, 1'($urandom),
                1'($urandom),
                ($urandom_range(99) < 70) ? code_pool[$urandom_range(15)] : 8'($urandom),
                ($urandom_range(99) < 10) ? 8'h00 : 8'($urandom));
      end else if (pick < 92) begin
        repeat ($urandom_range(1, 3))
          add_req(KIND_READ, 1'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
      end else if (pick < 96) begin
        add_req(KIND_NONE, 1'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 10))
          add_req(KIND_EDGE, 1'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
      end
    end
  endtask

  // Driver: a request is taken at an edge where valid and ready are both high.
  // The model sees it at that edge, then the next request may go up at once.
  always @(posedge clk) begin : drive
    kb_req_t nxt;
    logic    give;
    if (!rst_n) begin
      req_bus.valid <= 1'b0;
    end else begin
      if (req_bus.valid && req_bus.ready) due_resp.push_back(decode_request(shown));
      if (!req_bus.valid || req_bus.ready) begin
        give = (kb_reqs.size() != 0) && ($urandom_range(99) >= gap_pct);
        // A held request waits until the block has answered everything.
        if (give && kb_reqs[0].hold && due_resp.size() != 0) give = 1'b0;
        if (give) begin
          nxt = kb_reqs.pop_front();
          shown = nxt;
          req_bus.kind <= nxt.kind;
          req_bus.data_bit <= nxt.data_bit;
          req_bus.map_select <= nxt.map_select;
          req_bus.map_code <= nxt.map_code;
          req_bus.map_char <= nxt.map_char;
        end
        req_bus.valid <= give;
      end
    end
  end

  // Monitor: every taken response is checked against the oldest one still due.
  // Ready is rolled once per cycle, so it may drop whether or not a response waits.
  always @(posedge clk) begin : watch
    kb_resp_t want;
    if (rst_n && resp_bus.valid && resp_bus.ready) begin
      if (due_resp.size() == 0) begin
        report_mismatch("unexpected response", resp_bus.char_out, 0);
      end else begin
        want = due_resp.pop_front();
        if (resp_bus.char_out !== want.ch)
          report_mismatch("char_out", resp_bus.char_out, want.ch);
        if (resp_bus.char_valid !== want.vld)
          report_mismatch("char_valid", resp_bus.char_valid, want.vld);
      end
    end
    resp_bus.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Waits until the queue of requests has been shown and taken.
  task automatic drain_requests();
    while (kb_reqs.size() != 0 || req_bus.valid) @(posedge clk);
  endtask

  initial begin
    req_bus.valid = 1'b0;
    req_bus.kind = KIND_NONE;
    req_bus.data_bit = 1'b0;
    req_bus.map_select = 1'b0;
    req_bus.map_code = 8'h00;
    req_bus.map_char = 8'h00;
    resp_bus.ready = 1'b0;

    frame_phase = PHASE_IDLE;
    frame_bits = 8'h00;
    release_seen = 1'b0;
    shift_held = 1'b0;
    wr_idx = 0;
    rd_idx = 0;
    foreach (ring[i]) ring[i] = 8'h00;
    foreach (plain_chars[i]) plain_chars[i] = 8'h00;
    foreach (shifted_chars[i]) shifted_chars[i] = 8'h00;

    // Pool codes avoid zero, the release prefix and the shift keys, which
    // have rules of their own and get picked separately.
    foreach (code_pool[i]) begin
      code_pool[i] = 8'($urandom_range(1, 8'hEF));
      if (code_pool[i] == CODE_LSHIFT || code_pool[i] == CODE_RSHIFT) code_pool[i]++;
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: read of an empty buffer, the unused kind, map writes at the
    // extremes of code and character, entries for the shift keys, a stray high
    // edge while idle, and a full frame of scancode zero whose map entry is set.
    add_req(KIND_READ, 1'b0, 1'b0, 8'h00, 8'h00);
    add_req(KIND_NONE, 1'b1, 1'b1, 8'hFF, 8'hFF);
    add_req(KIND_MAP_WR, 1'b0, 1'b0, 8'h00, 8'hFF);
    add_req(KIND_MAP_WR, 1'b1, 1'b1, 8'hFF, 8'h80);
    add_req(KIND_MAP_WR, 1'b0, 1'b0, CODE_LSHIFT, 8'h01);
    add_req(KIND_MAP_WR, 1'b1, 1'b1, CODE_RSHIFT, 8'h7F);
    add_req(KIND_EDGE, 1'b1, 1'b0, 8'h00, 8'h00);
    add_frame(8'h00, 1'b1);
    add_req(KIND_READ, 1'b1, 1'b1, 8'hFF, 8'hFF);
    drain_requests();

    // Phase without idling: fill both maps for the pool codes, then a burst of
    // frames that stack up in the ring buffer before any read, then a mix.
    hold_next = 1'b1;
    foreach (code_pool[i]) begin
      add_req(KIND_MAP_WR, 1'($urandom), 1'b0, code_pool[i], 8'($urandom_range(1, 255)));
      add_req(KIND_MAP_WR, 1'($urandom), 1'b1, code_pool[i], 8'($urandom_range(1, 255)));
    end
    repeat (8) add_frame(code_pool[$urandom_range(15)], 1'b1);
    repeat (4) add_req(KIND_READ, 1'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
    add_random_mix(90);
    drain_requests();

    // Sender idles often; each phase starts by waiting for all responses.
    gap_pct = 61;
    hold_next = 1'b1;
    add_random_mix(90);
    drain_requests();

    // Receiver stalls often.
    gap_pct = 0;
    stall_pct = 61;
    hold_next = 1'b1;
    add_random_mix(90);
    drain_requests();

    // Both sides idle now and then.
    gap_pct = 20;
    stall_pct = 20;
    hold_next = 1'b1;
    add_random_mix(90);
    drain_requests();

    // Let the pipeline empty, then give a stray response time to show up.
    while (due_resp.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Guard against a hang; the run needs only a small part of this time,
  // including the map clearing pass after reset.
  initial begin
    #(8 * 400000);
    $display("TEST FAILED");
    $finish;
  end

endmodule
